// File: sv/assert_macros.svh
// assertion macros used by pointer_button_qualifier
// each macro expects clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PBQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define PBQ_ASSERT_NEVER(label, expr, msg) \
  `PBQ_ASSERT(label, !(expr), msg)

`endif

// File: sv/pbq_pkg.sv
// ----------------------------------------------------------------------------
// pbq_pkg
// Types and codes shared by the pointer button qualifier modules.
// ----------------------------------------------------------------------------
package pbq_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_INPUT_STYLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_STYLE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_LEFT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_TOP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT  = 3'd5;

  // input styles
  localparam logic [2:0] IN_NONE        = 3'd0;
  localparam logic [2:0] IN_PRESS_REL   = 3'd1;
  localparam logic [2:0] IN_STAY        = 3'd2;
  localparam logic [2:0] IN_ON_RELEASE  = 3'd3;
  localparam logic [2:0] IN_ON_PRESS    = 3'd4;
  localparam logic [2:0] IN_HELD        = 3'd5;
  localparam logic [2:0] IN_FOCUS       = 3'd6;

  // output styles
  localparam logic [1:0] OUT_NONE   = 2'd0;
  localparam logic [1:0] OUT_PULSE  = 2'd1;
  localparam logic [1:0] OUT_SELECT = 2'd2;
  localparam logic [1:0] OUT_TOGGLE = 2'd3;

  typedef struct packed {
    logic [2:0]         input_style;
    logic [1:0]         output_style;
    logic [COORD_W-1:0] rect_left;
    logic [COORD_W-1:0] rect_top;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } pbq_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pointer_x;
    logic [COORD_W-1:0] pointer_y;
    logic               went_down;
    logic               went_up;
    logic               held;
  } pbq_sample_t;

  typedef struct packed {
    logic over_now;
    logic over_before;
    logic down_was_over;
    logic up_was_over;
    logic left_mark;
    logic entered_mark;
    logic out_level;
  } pbq_state_t;

  localparam pbq_state_t STATE_RESET = '0;

endpackage

// File: sv/pointer_button_qualifier.sv
// ----------------------------------------------------------------------------
// pointer_button_qualifier
// Hit-tests pointer samples against a rectangle and qualifies button events.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready) takes one pointer sample per word: position
//   and the pressed, released and held flags of the primary button.
//   out channel (out_valid/out_ready) returns one result word per sample:
//   button_out, pointer_over, left_since_press, entered_since_press.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the style
//   and rectangle registers; it is always ready, and the user writes it only
//   while idle, which the block itself does not enforce.
// Path: a sample goes through the input register, then the result register.
// Throughput: one sample per cycle unless out stalls; the per-sample logic is
//   one 17-bit add and two compares per axis plus flag logic between the two
//   registers.
// Stall: when out_ready is low the result register holds and the input
//   register takes one more word; in_ready then drops until out drains.
// Reset: rst clears configuration, all marks and the output level, and
//   empties both registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pointer_button_qualifier (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pbq_pkg::COORD_W-1:0]     pointer_x,
  input  logic [pbq_pkg::COORD_W-1:0]     pointer_y,
  input  logic                            went_down,
  input  logic                            went_up,
  input  logic                            held,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            button_out,
  output logic                            pointer_over,
  output logic                            left_since_press,
  output logic                            entered_since_press,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pbq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pbq_pkg::pbq_cfg_t    cfg;
  pbq_pkg::pbq_sample_t sample;
  pbq_pkg::pbq_state_t  state;
  pbq_pkg::pbq_state_t  state_next;
  logic                 s1_valid;
  logic                 out_free;
  logic                 advance;

  // configuration registers
  pbq_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample <= '{pointer_x: pointer_x, pointer_y: pointer_y,
                  went_down: went_down, went_up: went_up, held: held};
    end
  end

  // per-tick logic
  pbq_core u_core (
    .cfg        (cfg),
    .sample     (sample),
    .state      (state),
    .state_next (state_next)
  );

  // tracked marks, updated once per word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pbq_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      button_out          <= state_next.out_level;
      pointer_over        <= state_next.over_now;
      left_since_press    <= state_next.left_mark;
      entered_since_press <= state_next.entered_mark;
    end
  end

  // checks
  `PBQ_ASSERT_NEVER(a_marks_exclusive, state.left_mark && state.entered_mark,
    "left and entered marks both set")
  `PBQ_ASSERT(a_none_holds, advance && (cfg.input_style == pbq_pkg::IN_NONE) |=>
    (state.out_level == $past(state.out_level)), "output level moved with no input style")
  `PBQ_ASSERT(a_ready_only_full, !in_ready |-> (s1_valid && out_valid && !out_ready),
    "input stalled with room in the pipeline")
  `PBQ_ASSERT(a_out_matches_state, out_valid |-> ((pointer_over == state.over_now)
    && (button_out == state.out_level)), "result word out of step with marks")

endmodule

// File: sv/pbq_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbq_cfg_regs
// Configuration register file, written one word at a time by index.
// ----------------------------------------------------------------------------
module pbq_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pbq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pbq_pkg::CFG_DATA_W-1:0]     cfg_data,
  output pbq_pkg::pbq_cfg_t                  cfg
);

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register write by index, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pbq_pkg::REG_INPUT_STYLE:  cfg.input_style  <= cfg_data[2:0];
        pbq_pkg::REG_OUTPUT_STYLE: cfg.output_style <= cfg_data[1:0];
        pbq_pkg::REG_RECT_LEFT:    cfg.rect_left    <= cfg_data;
        pbq_pkg::REG_RECT_TOP:     cfg.rect_top     <= cfg_data;
        pbq_pkg::REG_RECT_WIDTH:   cfg.rect_width   <= cfg_data;
        pbq_pkg::REG_RECT_HEIGHT:  cfg.rect_height  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/pbq_core.sv
// ----------------------------------------------------------------------------
// pbq_core
// Per-tick logic: hit test, mark update, click events and output style.
// ----------------------------------------------------------------------------
module pbq_core (
  input  pbq_pkg::pbq_cfg_t    cfg,
  input  pbq_pkg::pbq_sample_t sample,
  input  pbq_pkg::pbq_state_t  state,
  output pbq_pkg::pbq_state_t  state_next
);

  logic [pbq_pkg::COORD_W:0] right_edge;
  logic [pbq_pkg::COORD_W:0] bottom_edge;
  logic                      hit;
  logic                      dwo;
  logic                      uwo;
  logic                      click;
  logic                      unclick;
  logic                      active;

  // hit test, sums at one extra bit so they never wrap
  assign right_edge  = {1'b0, cfg.rect_left} + {1'b0, cfg.rect_width};
  assign bottom_edge = {1'b0, cfg.rect_top}  + {1'b0, cfg.rect_height};
  assign hit = (sample.pointer_x >= cfg.rect_left)
            && ({1'b0, sample.pointer_x} < right_edge)
            && (sample.pointer_y >= cfg.rect_top)
            && ({1'b0, sample.pointer_y} < bottom_edge);

  assign dwo = sample.went_down ? hit : state.down_was_over;
  assign uwo = sample.went_up   ? hit : state.up_was_over;

  assign active = (cfg.input_style inside {[pbq_pkg::IN_PRESS_REL:pbq_pkg::IN_FOCUS]})
               && (cfg.output_style != pbq_pkg::OUT_NONE);

  // marks
  always_comb begin
    state_next               = state;
    state_next.over_before   = state.over_now;
    state_next.over_now      = hit;
    state_next.down_was_over = dwo;
    state_next.up_was_over   = uwo;
    if (sample.went_down) begin
      state_next.left_mark    = 1'b0;
      state_next.entered_mark = 1'b0;
    end
    if (dwo && !hit) begin
      state_next.left_mark = 1'b1;
    end
    if (!dwo && hit) begin
      state_next.entered_mark = 1'b1;
    end

    // click events per input style
    click   = 1'b0;
    unclick = 1'b0;
    case (cfg.input_style)
      pbq_pkg::IN_PRESS_REL: begin
        if (sample.went_up) begin
          click   = dwo && uwo;
          unclick = !dwo && !uwo;
        end
      end
      pbq_pkg::IN_STAY: begin
        if (sample.went_up) begin
          if (dwo && uwo && !state_next.left_mark) begin
            click = 1'b1;
          end else if (!dwo && !uwo && !state_next.entered_mark) begin
            unclick = 1'b1;
          end
        end
      end
      pbq_pkg::IN_ON_RELEASE: begin
        if (sample.went_up) begin
          click   = hit;
          unclick = !hit;
        end
      end
      pbq_pkg::IN_ON_PRESS: begin
        if (sample.went_down) begin
          click   = hit;
          unclick = !hit;
        end
      end
      pbq_pkg::IN_HELD: begin
        if (sample.went_down) begin
          click = hit;
        end else if (sample.went_up) begin
          unclick = hit;
        end else if (sample.held) begin
          click   = !state.over_now && hit;
          unclick = state.over_now && !hit;
        end
      end
      pbq_pkg::IN_FOCUS: begin
        unclick = state.over_now && !hit;
        click   = sample.went_down && hit;
      end
      default: ;
    endcase

    // output style
    if (active) begin
      case (cfg.output_style)
        pbq_pkg::OUT_PULSE: state_next.out_level = click;
        pbq_pkg::OUT_SELECT: begin
          if (click) begin
            state_next.out_level = 1'b1;
          end else if (unclick) begin
            state_next.out_level = 1'b0;
          end
        end
        default: begin
          if (click) begin
            state_next.out_level = !state.out_level;
          end
        end
      endcase
    end
  end

endmodule

// File: sim/tb_pointer_button_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pointer_button_qualifier
// Self-checking bench for the pointer button qualifier. A queue of pointer
// samples feeds a clocked driver; a clocked monitor compares every result
// word with a cycle-free prediction of hit test, press marks and styles.
// Phases sweep every input and output style pair with varied rectangles and
// varied sender and receiver idling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pointer_button_qualifier;
  import pbq_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 11;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_LIMIT = 200;
  localparam int PHASES       = 32;
  localparam int PHASE_ITEMS  = 48;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic button_out;
    logic pointer_over;
    logic left_since_press;
    logic entered_since_press;
  } qual_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [COORD_W-1:0]     pointer_x = '0;
  logic [COORD_W-1:0]     pointer_y = '0;
  logic                   went_down = 1'b0;
  logic                   went_up = 1'b0;
  logic                   held = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   button_out;
  logic                   pointer_over;
  logic                   left_since_press;
  logic                   entered_since_press;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // shadow of the block's registers and marks
  pbq_cfg_t     shadow_cfg = '0;
  pbq_state_t   mirror = STATE_RESET;

  pbq_sample_t  pending_samples[$];
  qual_result_t expected_results[$];
  pbq_sample_t  offered;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int queued_items = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit pressure_req = 1'b0;
  bit pressure_seen = 1'b0;
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;

  pointer_button_qualifier u_top (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .pointer_x           (pointer_x),
    .pointer_y           (pointer_y),
    .went_down           (went_down),
    .went_up             (went_up),
    .held                (held),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .button_out          (button_out),
    .pointer_over        (pointer_over),
    .left_since_press    (left_since_press),
    .entered_since_press (entered_since_press),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // next result of the qualifier for one sample; advances the mirrored marks
  function automatic qual_result_t qualify_sample(input pbq_sample_t s);
    logic [16:0]  right_edge;
    logic [16:0]  bottom_edge;
    logic         hit;
    logic         click;
    logic         unclick;
    qual_result_t r;
    right_edge  = {1'b0, shadow_cfg.rect_left} + {1'b0, shadow_cfg.rect_width};
    bottom_edge = {1'b0, shadow_cfg.rect_top} + {1'b0, shadow_cfg.rect_height};
    hit = (s.pointer_x >= shadow_cfg.rect_left) && ({1'b0, s.pointer_x} < right_edge) &&
          (s.pointer_y >= shadow_cfg.rect_top) && ({1'b0, s.pointer_y} < bottom_edge);
    click   = 1'b0;
    unclick = 1'b0;

    // marks update in a fixed order: hover, press, release, leave/enter
    mirror.over_before = mirror.over_now;
    mirror.over_now    = hit;
    if (s.went_down) begin
      mirror.down_was_over = mirror.over_now;
      mirror.left_mark     = 1'b0;
      mirror.entered_mark  = 1'b0;
    end
    if (s.went_up) mirror.up_was_over = mirror.over_now;
    if (mirror.down_was_over && !mirror.over_now) mirror.left_mark = 1'b1;
    if (!mirror.down_was_over && mirror.over_now) mirror.entered_mark = 1'b1;

    // events, then output level; none or unused style holds the level
    if (shadow_cfg.input_style >= IN_PRESS_REL && shadow_cfg.input_style <= IN_FOCUS &&
        shadow_cfg.output_style != OUT_NONE) begin
      case (shadow_cfg.input_style)
        IN_PRESS_REL: begin
          if (s.went_up) begin
            if (mirror.down_was_over && mirror.up_was_over) click = 1'b1;
            else if (!mirror.down_was_over && !mirror.up_was_over) unclick = 1'b1;
          end
        end
        IN_STAY: begin
          if (s.went_up) begin
            if (mirror.down_was_over && mirror.up_was_over && !mirror.left_mark)
              click = 1'b1;
            else if (!mirror.down_was_over && !mirror.up_was_over && !mirror.entered_mark)
              unclick = 1'b1;
          end
        end
        IN_ON_RELEASE: begin
          if (s.went_up) begin
            click   = mirror.over_now;
            unclick = !mirror.over_now;
          end
        end
        IN_ON_PRESS: begin
          if (s.went_down) begin
            click   = mirror.over_now;
            unclick = !mirror.over_now;
          end
        end
        IN_HELD: begin
          if (s.went_down) click = mirror.over_now;
          else if (s.went_up) unclick = mirror.over_now;
          else if (s.held) begin
            click   = !mirror.over_before && mirror.over_now;
            unclick = mirror.over_before && !mirror.over_now;
          end
        end
        default: begin
          unclick = mirror.over_before && !mirror.over_now;
          click   = s.went_down && mirror.over_now;
        end
      endcase
      case (shadow_cfg.output_style)
        OUT_PULSE: mirror.out_level = click;
        OUT_SELECT: begin
          if (click) mirror.out_level = 1'b1;
          else if (unclick) mirror.out_level = 1'b0;
        end
        default: begin
          if (click) mirror.out_level = !mirror.out_level;
        end
      endcase
    end

    r.button_out          = mirror.out_level;
    r.pointer_over        = mirror.over_now;
    r.left_since_press    = mirror.left_mark;
    r.entered_since_press = mirror.entered_mark;
    return r;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $error("%s: expected %0b, got %0b", name, want, got);
    end
  endtask

  // sample driver: one word offered at a time, held until accepted
  always @(posedge clk) begin : sample_drive
    logic accepted;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) expected_results.push_back(qualify_sample(offered));
      if (!in_valid || accepted) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_samples.pop_front();
          pointer_x <= offered.pointer_x;
          pointer_y <= offered.pointer_y;
          went_down <= offered.went_down;
          went_up   <= offered.went_up;
          held      <= offered.held;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin : result_ready
    logic rdy;
    if (pressure_req && !pressure_seen) begin
      pressure_seen <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      rdy = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(99) >= recv_stall_pct);
    end
    out_ready <= rdy;
  end

  // result monitor
  always @(posedge clk) begin : result_check
    qual_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $error("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("button_out", want.button_out, button_out);
        check_field("pointer_over", want.pointer_over, pointer_over);
        check_field("left_since_press", want.left_since_press, left_since_press);
        check_field("entered_since_press", want.entered_since_press, entered_since_press);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INPUT_STYLE:  shadow_cfg.input_style  = data[2:0];
      REG_OUTPUT_STYLE: shadow_cfg.output_style = data[1:0];
      REG_RECT_LEFT:    shadow_cfg.rect_left    = data;
      REG_RECT_TOP:     shadow_cfg.rect_top     = data;
      REG_RECT_WIDTH:   shadow_cfg.rect_width   = data;
      REG_RECT_HEIGHT:  shadow_cfg.rect_height  = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic write_setup(input logic [2:0] in_style, input logic [1:0] out_style,
                             input logic [15:0] l, input logic [15:0] t,
                             input logic [15:0] w, input logic [15:0] h);
    write_register(REG_INPUT_STYLE, {13'd0, in_style});
    write_register(REG_OUTPUT_STYLE, {14'd0, out_style});
    write_register(REG_RECT_LEFT, l);
    write_register(REG_RECT_TOP, t);
    write_register(REG_RECT_WIDTH, w);
    write_register(REG_RECT_HEIGHT, h);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 69 : (mode == IDLE_BOTH) ? 10 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 69 : (mode == IDLE_BOTH) ? 10 : 0;
  endtask

  // wait until every word is through, then let the pipeline settle
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic push_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic dn, input logic up, input logic hd);
    pbq_sample_t s;
    s.pointer_x = x;
    s.pointer_y = y;
    s.went_down = dn;
    s.went_up   = up;
    s.held      = hd;
    pending_samples.push_back(s);
    queued_items++;
    last_x = x;
    last_y = y;
  endtask

  // coordinate on one axis, biased to the inside and the edges of the span
  function automatic logic [15:0] pick_coord(input logic [15:0] lo, input logic [15:0] len);
    logic [16:0] v;
    int          r;
    r = $urandom_range(99);
    if (r < 40) begin
      v = (len == 0) ? {1'b0, lo} : {1'b0, lo} + 17'($urandom_range(len - 1));
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: v = (lo == 0) ? 17'd0 : {1'b0, lo} - 17'd1;
        1: v = {1'b0, lo};
        2: v = {1'b0, lo} + {1'b0, len} - ((len == 0) ? 17'd0 : 17'd1);
        default: v = {1'b0, lo} + {1'b0, len};
      endcase
    end else begin
      v = 17'($urandom_range(65535));
    end
    return (v > 17'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  // next tick of a gesture: often the pointer stays put
  task automatic push_near(input logic dn, input logic up, input logic hd);
    if ($urandom_range(1) == 0)
      push_sample(last_x, last_y, dn, up, hd);
    else
      push_sample(pick_coord(shadow_cfg.rect_left, shadow_cfg.rect_width),
                  pick_coord(shadow_cfg.rect_top, shadow_cfg.rect_height), dn, up, hd);
  endtask

  // press, hold while moving, release, rest
  task automatic add_gesture();
    int holds;
    int rests;
    holds = $urandom_range(5);
    rests = $urandom_range(2);
    push_near(1'b1, 1'b0, 1'b1);
    repeat (holds) push_near(1'b0, 1'b0, 1'b1);
    push_near(1'b0, 1'b1, 1'b0);
    repeat (rests) push_near(1'b0, 1'b0, 1'b0);
  endtask

  initial begin : stimulus
    int          p;
    int          r;
    logic [15:0] l;
    logic [15:0] t;
    logic [15:0] w;
    logic [15:0] h;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: edges of a small rectangle under the stay style
    write_setup(IN_STAY, OUT_SELECT, 16'd100, 16'd200, 16'd50, 16'd30);
    set_idling(IDLE_NONE);
    @(negedge clk);
    push_sample(16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    push_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);  // press outside, all ones
    push_sample(16'd100, 16'd200, 1'b0, 1'b0, 1'b1);    // enter at the low corner
    push_sample(16'd150, 16'd200, 1'b0, 1'b1, 1'b0);    // release on the open right edge
    push_sample(16'd149, 16'd229, 1'b1, 1'b0, 1'b1);    // press at the high corner
    push_sample(16'd149, 16'd229, 1'b0, 1'b1, 1'b0);    // release over: click
    push_sample(16'd99, 16'd215, 1'b1, 1'b0, 1'b1);     // press just left
    push_sample(16'd120, 16'd230, 1'b0, 1'b1, 1'b0);    // release just below: unclick
    push_sample(16'd120, 16'd215, 1'b1, 1'b1, 1'b1);    // press and release together, over
    push_sample(16'd120, 16'd199, 1'b1, 1'b1, 1'b0);    // press and release together, out
    push_sample(16'd125, 16'd215, 1'b1, 1'b0, 1'b1);
    push_sample(16'd160, 16'd215, 1'b0, 1'b0, 1'b1);    // leave after pressing over
    push_sample(16'd125, 16'd215, 1'b0, 1'b1, 1'b0);    // back over, no click
    push_sample(16'd60, 16'd60, 1'b1, 1'b0, 1'b1);
    push_sample(16'd125, 16'd215, 1'b0, 1'b0, 1'b1);    // enter after pressing outside
    push_sample(16'd60, 16'd60, 1'b0, 1'b1, 1'b0);      // release out, no unclick
    drain();

    // directed: rectangle reaching past the coordinate range, held style
    write_setup(IN_HELD, OUT_TOGGLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    @(negedge clk);
    push_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    push_sample(16'hFFFE, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    push_sample(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b1);
    push_sample(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0);
    push_sample(16'd0, 16'd0, 1'b0, 1'b0, 1'b1);
    drain();

    // directed: zero width hits nothing, focus style
    write_setup(IN_FOCUS, OUT_PULSE, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    @(negedge clk);
    push_sample(16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
    push_sample(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    drain();

    // random phases over every style pair
    for (p = 0; p < PHASES; p++) begin
      case ($urandom_range(9))
        0: begin
          l = 16'($urandom_range(65535));
          t = 16'($urandom_range(65535));
          w = $urandom_range(1) ? 16'd0 : 16'($urandom_range(2000));
          h = (w == 0) ? 16'($urandom_range(2000)) : 16'd0;
        end
        1: begin
          l = 16'd0;
          t = 16'd0;
          w = 16'hFFFF;
          h = 16'hFFFF;
        end
        2: begin
          l = 16'hFFFF - 16'($urandom_range(300));
          t = 16'hFFFF - 16'($urandom_range(300));
          w = 16'hFFFF - 16'($urandom_range(300));
          h = 16'hFFFF - 16'($urandom_range(300));
        end
        default: begin
          l = 16'($urandom_range(65535));
          t = 16'($urandom_range(65535));
          w = 16'($urandom_range(1, 2000));
          h = 16'($urandom_range(1, 2000));
        end
      endcase
      write_setup(3'(p % 8), 2'(p / 8), l, t, w, h);
      set_idling(idle_mode_t'((p + p / 8) % 4));
      @(negedge clk);
      if (p == 4) pressure_req = 1'b1;
      last_x = pick_coord(l, w);
      last_y = pick_coord(t, h);
      queued_items = 0;
      while (queued_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 75) begin
          add_gesture();
        end else if (r < 85) begin
          push_near(1'b1, 1'b1, 1'($urandom_range(1)));
        end else begin
          repeat ($urandom_range(1, 3))
            push_sample(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                        1'($urandom_range(1)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
        end
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      fail_count++;
      $error("%0d results never arrived", expected_results.size());
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: pointer_button_qualifier.f
+incdir+sv
sv/pbq_pkg.sv
sv/pbq_cfg_regs.sv
sv/pbq_core.sv
sv/pointer_button_qualifier.sv
sim/tb_pointer_button_qualifier.sv
